/* rtl/core/prq_pkg.sv */
// Package for the priority ready queue scheduler.
// Holds the transaction payload types, operation and status codes, the
// controller state type and the command bundle for the thread entry store.
package prq_pkg;

   localparam int OP_W      = 2;
   localparam int TID_W     = 6;
   localparam int PRIO_W    = 4;
   localparam int STATUS_W  = 2;
   // Widest thread index the entry store can be built with.
   localparam int IDX_MAX_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 2'd0,
      OP_PICK = 2'd1,
      OP_PARK = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_BAD_PRIO = 2'd2,
      ST_DUP      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEVEL,
      S_ENTRY,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [TID_W-1:0]  thread_id;
      logic [PRIO_W-1:0] priority_req;
      logic              thread_idle;
      logic              thread_running;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TID_W-1:0]    picked_thread;
      logic                picked_idle;
      logic                switched;
   } rsp_type;

   // One access to the entry memory per cycle plus a queued-flag update.
   typedef struct packed {
      logic                 rd_en;
      logic                 link_we;
      logic                 idle_we;
      logic [IDX_MAX_W-1:0] addr;
      logic [IDX_MAX_W-1:0] link;
      logic                 idle;
      logic                 q_set;
      logic                 q_clr;
      logic [IDX_MAX_W-1:0] q_addr;
   } thread_cmd_type;

   typedef struct packed {
      logic                 queued;
      logic [IDX_MAX_W-1:0] link;
      logic                 idle;
   } thread_rsp_type;

endpackage

/* rtl/core/prq_req_if.sv */
// Request channel of the priority ready queue scheduler.
// Valid/ready handshake with the request fields; widths from prq_pkg.
interface prq_req_if;
   logic                          valid;
   logic                          ready;
   logic [prq_pkg::OP_W-1:0]      operation;
   logic [prq_pkg::TID_W-1:0]     thread_id;
   logic [prq_pkg::PRIO_W-1:0]    priority_req;
   logic                          thread_idle;
   logic                          thread_running;

   modport source (
      output valid, operation, thread_id, priority_req, thread_idle, thread_running,
      input  ready
   );
   modport sink (
      input  valid, operation, thread_id, priority_req, thread_idle, thread_running,
      output ready
   );
endinterface

/* rtl/core/prq_rsp_if.sv */
// Response channel of the priority ready queue scheduler.
// Valid/ready handshake with the result fields; widths from prq_pkg.
interface prq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [prq_pkg::STATUS_W-1:0]  status;
   logic [prq_pkg::TID_W-1:0]     picked_thread;
   logic                          picked_idle;
   logic                          switched;

   modport source (
      output valid, status, picked_thread, picked_idle, switched,
      input  ready
   );
   modport sink (
      input  valid, status, picked_thread, picked_idle, switched,
      output ready
   );
endinterface

/* rtl/core/prq_thread_store.sv */
// Per-thread storage: link and idle mark in one synchronous memory,
// plus the queued flags in flip-flops. Uses prq_pkg command types.
module prq_thread_store #(
   parameter int MAX_THREADS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  prq_pkg::thread_cmd_type cmd,
   output prq_pkg::thread_rsp_type rsp
);

   localparam int IDX_W = $clog2(MAX_THREADS);

   // Each word holds {link, idle}; the two fields are written separately.
   logic [IDX_W:0]           entry_mem [MAX_THREADS];
   logic [IDX_W:0]           rd_ff;
   logic [MAX_THREADS-1:0]   queued_ff;
   logic [IDX_W-1:0]         addr;
   logic [IDX_W-1:0]         q_idx;
   logic                     q_in_range;

   assign addr       = cmd.addr[IDX_W-1:0];
   assign q_idx      = cmd.q_addr[IDX_W-1:0];
   assign q_in_range = (32'(cmd.q_addr) < MAX_THREADS);

   always_ff @(posedge clock) begin
      if (cmd.link_we) begin
         entry_mem[addr][IDX_W:1] <= cmd.link[IDX_W-1:0];
      end
      if (cmd.idle_we) begin
         entry_mem[addr][0] <= cmd.idle;
      end
      if (cmd.rd_en) begin
         rd_ff <= entry_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= '0;
      end else if (cmd.q_set) begin
         queued_ff[q_idx] <= 1'b1;
      end else if (cmd.q_clr) begin
         queued_ff[q_idx] <= 1'b0;
      end
   end

   assign rsp.queued = q_in_range ? queued_ff[q_idx] : 1'b0;
   assign rsp.link   = prq_pkg::IDX_MAX_W'(rd_ff[IDX_W:1]);
   assign rsp.idle   = rd_ff[0];

endmodule

/* rtl/core/priority_ready_queue_scheduler_top.sv */
// Priority ready queue scheduler: one FIFO list of threads per priority.
// Each request passes the level table read, then one entry memory access,
// then the response register. No new request is taken before its response
// is loaded, so a stalled response holds off the next one. Synchronous
// reset empties all levels and clears the queued flags at once; the list
// memories keep their contents.
module priority_ready_queue_scheduler_top #(
   parameter int NUM_LEVELS  = 10,
   parameter int MAX_THREADS = 64
) (
   input  logic      clock,
   input  logic      reset,
   prq_req_if.sink   req_if,
   prq_rsp_if.source rsp_if
);

   localparam int LVL_W = $clog2(NUM_LEVELS);
   localparam int IDX_W = $clog2(MAX_THREADS);
   localparam int IW    = prq_pkg::IDX_MAX_W;

   prq_pkg::state_type      state_ff, state_in;
   prq_pkg::req_type        req_now, req_ff;
   prq_pkg::op_type         op_now, op_ff;
   prq_pkg::thread_cmd_type thr_cmd;
   prq_pkg::thread_rsp_type thr_rsp;
   prq_pkg::rsp_type        res_now, res_ff, rsp_ff;
   prq_pkg::status_type     status_lvl, status_ff;

   logic [2*IDX_W-1:0]    level_mem [NUM_LEVELS];
   logic [2*IDX_W-1:0]    level_rd_ff;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;

   logic [LVL_W-1:0] lvl_ff, lvl_sel, top_lvl;
   logic             prio_ok_ff, tid_ok_ff, empty_ff;
   logic [IDX_W-1:0] head_ff, tail_ff;
   logic             last_ff, pick_ok_ff, enq_ok_ff, switched_ff;
   logic             rsp_valid_ff;

   logic             req_accept, req_ready, out_free, load_rsp;
   logic             prio_ok_now, tid_ok_now;
   logic             lvl_re, lvl_we;
   logic [2*IDX_W-1:0] lvl_wdata;
   logic [IDX_W-1:0] head_rd, tail_rd, tid_idx;
   logic             enq_req, enq_ok, pick_ok;

   // ---------------------------------------------------------------- input
   assign req_now.operation      = req_if.operation;
   assign req_now.thread_id      = req_if.thread_id;
   assign req_now.priority_req   = req_if.priority_req;
   assign req_now.thread_idle    = req_if.thread_idle;
   assign req_now.thread_running = req_if.thread_running;

   assign req_if.ready = req_ready;
   assign req_accept   = req_if.valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign op_now      = prq_pkg::op_type'(req_now.operation);
   assign prio_ok_now = (32'(req_now.priority_req) < NUM_LEVELS);
   assign tid_ok_now  = (32'(req_now.thread_id) < MAX_THREADS);

   // Highest level with a queued thread; later iterations win.
   always_comb begin
      top_lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (nonempty_ff[i]) begin
            top_lvl = LVL_W'(i);
         end
      end
   end

   always_comb begin
      if (op_now == prq_pkg::OP_PICK) begin
         lvl_sel = top_lvl;
      end else if (prio_ok_now) begin
         lvl_sel = LVL_W'(req_now.priority_req);
      end else begin
         lvl_sel = '0;
      end
   end

   // ------------------------------------------------------- level decision
   assign op_ff   = prq_pkg::op_type'(req_ff.operation);
   assign head_rd = level_rd_ff[2*IDX_W-1:IDX_W];
   assign tail_rd = level_rd_ff[IDX_W-1:0];
   assign tid_idx = IDX_W'(req_ff.thread_id);

   assign enq_req = (op_ff == prq_pkg::OP_ADD) ||
                    ((op_ff == prq_pkg::OP_PARK) && !req_ff.thread_running);
   assign enq_ok  = enq_req && prio_ok_ff && tid_ok_ff && !thr_rsp.queued;
   assign pick_ok = (op_ff == prq_pkg::OP_PICK) && !empty_ff;

   always_comb begin
      status_lvl = prq_pkg::ST_OK;
      if (op_ff == prq_pkg::OP_PICK) begin
         if (empty_ff) begin
            status_lvl = prq_pkg::ST_EMPTY;
         end
      end else if (enq_req) begin
         if (!(prio_ok_ff && tid_ok_ff)) begin
            status_lvl = prq_pkg::ST_BAD_PRIO;
         end else if (thr_rsp.queued) begin
            status_lvl = prq_pkg::ST_DUP;
         end
      end
   end

   always_comb begin
      res_now.status        = status_ff;
      res_now.picked_thread = pick_ok_ff ? prq_pkg::TID_W'(head_ff) : '0;
      res_now.picked_idle   = pick_ok_ff ? thr_rsp.idle : 1'b0;
      res_now.switched      = switched_ff;
   end

   // ------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prq_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = prq_pkg::S_LEVEL;
            end
         end
         prq_pkg::S_LEVEL: begin
            state_in = prq_pkg::S_ENTRY;
         end
         prq_pkg::S_ENTRY, prq_pkg::S_REPLY: begin
            state_in = out_free ? prq_pkg::S_IDLE : prq_pkg::S_REPLY;
         end
         default: begin
            state_in = prq_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------ state outputs
   always_comb begin
      req_ready   = 1'b0;
      load_rsp    = 1'b0;
      lvl_re      = 1'b0;
      lvl_we      = 1'b0;
      lvl_wdata   = {head_rd, tid_idx};
      nonempty_in = nonempty_ff;
      thr_cmd     = '0;
      case (state_ff)
         prq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            lvl_re    = req_accept;
         end
         prq_pkg::S_LEVEL: begin
            thr_cmd.q_addr = pick_ok ? IW'(head_rd) : IW'(tid_idx);
            if (enq_ok) begin
               // Append: link the old tail when the level already has threads.
               lvl_we = 1'b1;
               if (nonempty_ff[lvl_ff]) begin
                  lvl_wdata       = {head_rd, tid_idx};
                  thr_cmd.link_we = 1'b1;
                  thr_cmd.addr    = IW'(tail_rd);
                  thr_cmd.link    = IW'(tid_idx);
               end else begin
                  lvl_wdata = {tid_idx, tid_idx};
               end
               nonempty_in[lvl_ff] = 1'b1;
               thr_cmd.q_set       = 1'b1;
            end else if (pick_ok) begin
               thr_cmd.rd_en = 1'b1;
               thr_cmd.addr  = IW'(head_rd);
               thr_cmd.q_clr = 1'b1;
               if (head_rd == tail_rd) begin
                  nonempty_in[lvl_ff] = 1'b0;
               end
            end
         end
         prq_pkg::S_ENTRY: begin
            load_rsp = out_free;
            if (enq_ok_ff) begin
               thr_cmd.idle_we = 1'b1;
               thr_cmd.addr    = IW'(tid_idx);
               thr_cmd.idle    = req_ff.thread_idle;
            end else if (pick_ok_ff && !last_ff) begin
               // The successor of the picked thread becomes the new head.
               lvl_we    = 1'b1;
               lvl_wdata = {thr_rsp.link[IDX_W-1:0], tail_ff};
            end
         end
         prq_pkg::S_REPLY: begin
            load_rsp = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::S_IDLE;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         nonempty_ff <= nonempty_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff     <= req_now;
         lvl_ff     <= lvl_sel;
         prio_ok_ff <= prio_ok_now;
         tid_ok_ff  <= tid_ok_now;
         empty_ff   <= ~|nonempty_ff;
      end
      if (state_ff == prq_pkg::S_LEVEL) begin
         head_ff     <= head_rd;
         tail_ff     <= tail_rd;
         last_ff     <= (head_rd == tail_rd);
         pick_ok_ff  <= pick_ok;
         enq_ok_ff   <= enq_ok;
         status_ff   <= status_lvl;
         switched_ff <= enq_ok && (op_ff == prq_pkg::OP_PARK);
      end
      if (state_ff == prq_pkg::S_ENTRY) begin
         res_ff <= res_now;
      end
      if (load_rsp) begin
         rsp_ff <= (state_ff == prq_pkg::S_ENTRY) ? res_now : res_ff;
      end
   end

   // Level table: {head, tail} per priority level.
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         level_mem[lvl_ff] <= lvl_wdata;
      end
      if (lvl_re) begin
         level_rd_ff <= level_mem[lvl_sel];
      end
   end

   prq_thread_store #(
      .MAX_THREADS (MAX_THREADS)
   ) u_thread_store (
      .clock (clock),
      .reset (reset),
      .cmd   (thr_cmd),
      .rsp   (thr_rsp)
   );

   // ------------------------------------------------------ output
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_ff.status;
   assign rsp_if.picked_thread = rsp_ff.picked_thread;
   assign rsp_if.picked_idle   = rsp_ff.picked_idle;
   assign rsp_if.switched      = rsp_ff.switched;

endmodule

/* rtl/core/prq_checker.sv */
// Port-level checks for the priority ready queue scheduler.
// Uses prq_pkg status codes; bound to priority_ready_queue_scheduler_top.
module prq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [prq_pkg::STATUS_W-1:0] rsp_status,
   input logic [prq_pkg::TID_W-1:0]    rsp_picked_thread,
   input logic                         rsp_picked_idle,
   input logic                         rsp_switched
);

   // A stalled response keeps its transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_picked_thread) && $stable(rsp_picked_idle) && $stable(rsp_switched))
      else $error("response changed while stalled");

   // Requests are processed one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // A switch is only reported for a successful park, which picks nothing.
   a_switch_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |->
      rsp_status == prq_pkg::ST_OK && rsp_picked_thread == '0 && !rsp_picked_idle)
      else $error("switch reported with inconsistent fields");

   // An empty pick returns no thread.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == prq_pkg::ST_EMPTY |->
      rsp_picked_thread == '0 && !rsp_picked_idle && !rsp_switched)
      else $error("empty pick returned a thread");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind priority_ready_queue_scheduler_top prq_checker u_prq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_picked_thread (rsp_if.picked_thread),
   .rsp_picked_idle   (rsp_if.picked_idle),
   .rsp_switched      (rsp_if.switched)
);
